>>> src/cidp_pkg.sv
// ----------------------------------------------------------------------------
// cidp_pkg: shared types and constants for the caller ID frame parser
// Result word layout, kind codes, parser phases and protocol byte values.
// ----------------------------------------------------------------------------
package cidp_pkg;

  // Body byte that classifies the frame (first byte after date and time)
  localparam int NUMBER_OFFSET_DEF = 8;

  localparam int IDX_W = 9;

  // Protocol byte values
  localparam logic [7:0] TYPE_SDMF    = 8'h04;
  localparam logic [7:0] TYPE_MDMF    = 8'h80;
  localparam logic [7:0] CHAR_OUTAREA = 8'h4F;
  localparam logic [7:0] CHAR_PRIVATE = 8'h50;

  // Result kind codes
  typedef enum logic [1:0] {
    KIND_CHAR    = 2'd0,
    KIND_OUTAREA = 2'd1,
    KIND_PRIVATE = 2'd2,
    KIND_END     = 2'd3
  } kind_t;

  // Parser phase
  typedef enum logic [1:0] {
    PH_HUNT = 2'd0,
    PH_LEN  = 2'd1,
    PH_BODY = 2'd2
  } phase_t;

  // One result word
  typedef struct packed {
    kind_t      kind;
    logic [7:0] char_value;
    logic       last;
  } result_t;

  // Results produced by one input byte (0, 1 or 2 words)
  typedef struct packed {
    logic [1:0] cnt;
    result_t    r0;
    result_t    r1;
  } push_t;

endpackage

>>> src/cidp_parse.sv
// ----------------------------------------------------------------------------
// cidp_parse: frame state and per-byte decode
// Tracks hunt/length/body phase and emits up to two result words per byte.
// ----------------------------------------------------------------------------
module cidp_parse #(
  parameter int NUMBER_OFFSET = cidp_pkg::NUMBER_OFFSET_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                take,
  input  logic [7:0]          rx_byte,
  output cidp_pkg::push_t     push
);

  localparam logic [cidp_pkg::IDX_W-1:0] OFFSET = cidp_pkg::IDX_W'(NUMBER_OFFSET);

  cidp_pkg::phase_t             phase_r, phase_nxt;
  logic [cidp_pkg::IDX_W-1:0]   body_length_r, body_length_nxt;
  logic [cidp_pkg::IDX_W-1:0]   body_index_r, body_index_nxt;
  logic                         suppress_r, suppress_nxt;

  logic [cidp_pkg::IDX_W-1:0]   idx_inc;
  logic                         is_last;
  logic                         cls_v;
  cidp_pkg::result_t            cls;
  cidp_pkg::result_t            eom;

  assign idx_inc = body_index_r + cidp_pkg::IDX_W'(1);
  assign is_last = (idx_inc == body_length_r);

  // Advance the phase
  always_comb begin
    phase_nxt = phase_r;
    case (phase_r)
      cidp_pkg::PH_LEN: begin
        phase_nxt = cidp_pkg::PH_BODY;
      end
      cidp_pkg::PH_BODY: begin
        if (is_last) begin
          phase_nxt = cidp_pkg::PH_HUNT;
        end
      end
      default: begin
        if (rx_byte == cidp_pkg::TYPE_MDMF || rx_byte == cidp_pkg::TYPE_SDMF) begin
          phase_nxt = cidp_pkg::PH_LEN;
        end else begin
          phase_nxt = cidp_pkg::PH_HUNT;
        end
      end
    endcase
  end

  // Decode the byte into counters and result words
  always_comb begin
    body_length_nxt = body_length_r;
    body_index_nxt  = body_index_r;
    suppress_nxt    = suppress_r;
    cls_v           = 1'b0;
    cls             = '{kind: cidp_pkg::KIND_CHAR, char_value: rx_byte, last: 1'b0};
    eom             = '{kind: cidp_pkg::KIND_END, char_value: 8'd0, last: 1'b1};
    push            = '0;
    case (phase_r)
      cidp_pkg::PH_LEN: begin
        body_length_nxt = {1'b0, rx_byte} + cidp_pkg::IDX_W'(1);
        body_index_nxt  = '0;
        suppress_nxt    = 1'b0;
      end
      cidp_pkg::PH_BODY: begin
        // classify the frame, or pass a number character
        if (body_index_r == OFFSET) begin
          if (rx_byte == cidp_pkg::CHAR_OUTAREA) begin
            cls_v        = 1'b1;
            cls          = '{kind: cidp_pkg::KIND_OUTAREA, char_value: 8'd0, last: 1'b0};
            suppress_nxt = 1'b1;
          end else if (rx_byte == cidp_pkg::CHAR_PRIVATE) begin
            cls_v        = 1'b1;
            cls          = '{kind: cidp_pkg::KIND_PRIVATE, char_value: 8'd0, last: 1'b0};
            suppress_nxt = 1'b1;
          end else begin
            cls_v = !is_last;
          end
        end else if (body_index_r > OFFSET && !is_last && !suppress_r) begin
          cls_v = 1'b1;
        end
        // close the frame on the checksum byte
        if (is_last) begin
          body_index_nxt = '0;
        end else begin
          body_index_nxt = idx_inc;
        end
        if (cls_v && is_last) begin
          push.cnt = 2'd2;
          push.r0  = cls;
          push.r1  = eom;
        end else if (cls_v) begin
          push.cnt     = 2'd1;
          push.r0      = cls;
          push.r0.last = 1'b1;
        end else if (is_last) begin
          push.cnt = 2'd1;
          push.r0  = eom;
        end
      end
      default: begin
      end
    endcase
    if (!take) begin
      push.cnt = 2'd0;
    end
  end

  // Hold state until a byte is taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r       <= cidp_pkg::PH_HUNT;
      body_length_r <= '0;
      body_index_r  <= '0;
      suppress_r    <= 1'b0;
    end else if (take) begin
      phase_r       <= phase_nxt;
      body_length_r <= body_length_nxt;
      body_index_r  <= body_index_nxt;
      suppress_r    <= suppress_nxt;
    end
  end

endmodule

>>> src/cidp_out_queue.sv
// ----------------------------------------------------------------------------
// cidp_out_queue: result word queue
// Four-word queue: up to two words in per cycle, one out per ready cycle.
// ----------------------------------------------------------------------------
module cidp_out_queue (
  input  logic                clk,
  input  logic                rst_n,
  input  cidp_pkg::push_t     push,
  output logic                room,
  output logic                out_valid,
  input  logic                out_ready,
  output cidp_pkg::result_t   out_word
);

  cidp_pkg::result_t slot_r [4];
  logic [1:0] head_r, head_nxt;
  logic [1:0] tail_r, tail_nxt;
  logic [2:0] count_r, count_nxt;
  logic       pop;
  logic [1:0] tail_p1;

  assign room      = (count_r <= 3'd2);
  assign out_valid = (count_r != 3'd0);
  assign out_word  = slot_r[head_r];
  assign pop       = out_valid && out_ready;
  assign tail_p1   = tail_r + 2'd1;

  // Advance pointers and fill level
  always_comb begin
    head_nxt  = pop ? head_r + 2'd1 : head_r;
    tail_nxt  = tail_r + push.cnt;
    count_nxt = count_r + {1'b0, push.cnt} - {2'b00, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r  <= '0;
      tail_r  <= '0;
      count_r <= '0;
    end else begin
      head_r  <= head_nxt;
      tail_r  <= tail_nxt;
      count_r <= count_nxt;
    end
  end

  // Write incoming words
  always_ff @(posedge clk) begin
    if (push.cnt != 2'd0) begin
      slot_r[tail_r] <= push.r0;
    end
    if (push.cnt == 2'd2) begin
      slot_r[tail_p1] <= push.r1;
    end
  end

endmodule

>>> src/caller_id_frame_parser.sv
// ----------------------------------------------------------------------------
// caller_id_frame_parser: caller ID message parser
// Finds frames in a decoded byte stream and reports number characters,
// out-of-area or private classification, and end of message.
// ----------------------------------------------------------------------------
// Input channel: one received byte per word on in_rx_byte (valid/ready).
// Bytes are dropped until a type byte; the next byte is the length, then
// the body of length+1 bytes, the last one being the checksum.
// Output channel: result words (out_kind, out_char_value, out_last), at
// most two per input byte; out_last marks the final word of a byte.
// Result words are registered in the queue as the byte is taken and
// offered behind any words already waiting. Throughput: one byte per
// cycle while the receiver drains one word per cycle; a byte that yields
// two words holds the output longer, and that port sets the sustained rate.
// A four-word queue sits between decode and output: in_ready is high
// while it has room for two words, so a stalled receiver throttles input
// once three or four words wait (at most three bytes of backlog) and no
// word is ever lost.
// Reset (rst_n low, synchronous) empties the queue and returns the parser
// to hunting for a type byte.
// ----------------------------------------------------------------------------
module caller_id_frame_parser #(
  parameter int NUMBER_OFFSET = cidp_pkg::NUMBER_OFFSET_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_rx_byte,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [1:0] out_kind,
  output logic [7:0] out_char_value,
  output logic       out_last
);

  cidp_pkg::push_t   push;
  cidp_pkg::result_t word;
  logic              room;
  logic              take;

  assign in_ready = room;
  assign take     = in_valid && room;

  // Decode bytes
  cidp_parse #(
    .NUMBER_OFFSET (NUMBER_OFFSET)
  ) u_parse (
    .clk     (clk),
    .rst_n   (rst_n),
    .take    (take),
    .rx_byte (in_rx_byte),
    .push    (push)
  );

  // Queue result words
  cidp_out_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .room      (room),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_word  (word)
  );

  assign out_kind       = word.kind;
  assign out_char_value = word.char_value;
  assign out_last       = word.last;

endmodule

>>> src/cidp_checker.sv
// ----------------------------------------------------------------------------
// cidp_checker: port-level checks for the caller ID frame parser
// Watches the result channel for stalls, word contents and reset.
// ----------------------------------------------------------------------------
module cidp_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_ready,
  input logic [1:0] out_kind,
  input logic [7:0] out_char_value,
  input logic       out_last
);

  // Hold a stalled word
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_kind)
      && $stable(out_char_value) && $stable(out_last))
    else $error("result word changed while stalled");

  // Non-character words carry a zero value
  a_zero_value: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind != cidp_pkg::KIND_CHAR |-> out_char_value == 8'd0)
    else $error("nonzero value on a non-character word");

  // End of message always closes its byte
  a_end_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind == cidp_pkg::KIND_END |-> out_last)
    else $error("end of message word without last");

  // Drop all words on reset
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result offered right after reset");

endmodule

bind caller_id_frame_parser cidp_checker u_cidp_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .out_valid      (out_valid),
  .out_ready      (out_ready),
  .out_kind       (out_kind),
  .out_char_value (out_char_value),
  .out_last       (out_last)
);
